// File: rtl/core/atla_pkg.sv
// Shared types, constants and the arctangent table of the tilt angle unit.
package atla_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W = 20;
  localparam int CFG_W = 5;
  localparam int MAX_SAMPLES = 16;
  localparam int CFG_RESET = 10;
  localparam int ANGLE_FRACTION_BITS = 8;
  localparam int FINE_BITS = 24;
  localparam int ROUND_SHIFT = FINE_BITS - ANGLE_FRACTION_BITS;
  localparam int CORDIC_STEPS = 28;
  localparam int WIDE_W = 58;
  localparam int ANGLE_W = 34;
  localparam int ROUND_W = ANGLE_W - ROUND_SHIFT;
  localparam int STEP_W = 5;
  localparam int ROLL_W = 17;
  localparam int PITCH_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [ROLL_W-1:0] roll_t;
  typedef logic signed [PITCH_W-1:0] pitch_t;

  localparam angle_t DEG90_FINE = ANGLE_W'(90) <<< FINE_BITS;
  localparam step_t LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef struct packed {
    logic  start;
    wide_t x;
    wide_t y;
  } cordic_req_t;

  typedef struct packed {
    logic   done;
    wide_t  mag;
    angle_t angle;
  } cordic_rsp_t;

  function automatic angle_t atan_entry(input step_t idx);
    angle_t val;
    unique case (idx)
      5'd0:    val = 34'sd754974720;
      5'd1:    val = 34'sd445687602;
      5'd2:    val = 34'sd235489088;
      5'd3:    val = 34'sd119537938;
      5'd4:    val = 34'sd60000934;
      5'd5:    val = 34'sd30029717;
      5'd6:    val = 34'sd15018523;
      5'd7:    val = 34'sd7509720;
      5'd8:    val = 34'sd3754917;
      5'd9:    val = 34'sd1877466;
      5'd10:   val = 34'sd938734;
      5'd11:   val = 34'sd469367;
      5'd12:   val = 34'sd234684;
      5'd13:   val = 34'sd117342;
      5'd14:   val = 34'sd58671;
      5'd15:   val = 34'sd29335;
      5'd16:   val = 34'sd14668;
      5'd17:   val = 34'sd7334;
      5'd18:   val = 34'sd3667;
      5'd19:   val = 34'sd1833;
      5'd20:   val = 34'sd917;
      5'd21:   val = 34'sd458;
      5'd22:   val = 34'sd229;
      5'd23:   val = 34'sd115;
      5'd24:   val = 34'sd57;
      5'd25:   val = 34'sd29;
      5'd26:   val = 34'sd14;
      5'd27:   val = 34'sd7;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/atla_if.sv
// Request channel interfaces for accelerometer samples and tilt angle results.
interface atla_sample_if;
  logic               valid;
  logic               ready;
  atla_pkg::sample_t  accel_x;
  atla_pkg::sample_t  accel_y;
  atla_pkg::sample_t  accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atla_angle_if;
  logic             valid;
  logic             ready;
  atla_pkg::roll_t  roll_angle;
  atla_pkg::pitch_t pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// File: rtl/core/accelerometer_block_tilt_angles_unit.sv
// Top level of the accelerometer block tilt angle unit.
// Each accepted sample is added to the block sums. The sample that completes a block starts
// the angle computation, and the unit is not ready until the output register is loaded: two
// 28-step vectoring passes of the single shared CORDIC stage, each with a state to load
// the pass and a wait for its result, a multiply state for the pitch input and a final
// state to load the output register. A pass that gets the zero vector hands over its result
// in the cycle after its load. The final state is held while an earlier result still waits in
// the output register. The result waits in an output register, and samples of the next
// block are accepted while it waits.
module accelerometer_block_tilt_angles_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [atla_pkg::CFG_W-1:0] cfg_wdata_i,
  atla_sample_if.sink            sample_i,
  atla_angle_if.source           angle_o
);
  import atla_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_START1 = 7'b0000010,
    ST_PASS1  = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_START2 = 7'b0010000,
    ST_PASS2  = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_e;

  localparam logic signed [33:0] GAIN_Q = 34'sd7072781453;
  localparam logic signed [ROUND_W-1:0] ROLL_LIM = ROUND_W'(180 << ANGLE_FRACTION_BITS);
  localparam logic signed [ROUND_W-1:0] PITCH_LIM = ROUND_W'(90 << ANGLE_FRACTION_BITS);

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [CFG_W-1:0]   count_q, count_d;
  logic [CFG_W-1:0]   block;
  sum_t               sum_x_q, sum_x_d;
  sum_t               sum_y_q, sum_y_d;
  sum_t               sum_z_q, sum_z_d;
  wide_t              prod_q;
  logic signed [53:0] prod;
  angle_t             roll_z_q;
  logic               out_valid_q;
  roll_t              roll_q;
  pitch_t             pitch_q;
  logic               accept;
  logic               last_sample;
  logic               load_out;
  logic signed [SUM_W:0] neg_y;
  logic signed [SUM_W:0] neg_z;
  cordic_req_t        creq;
  cordic_rsp_t        crsp;
  logic signed [ROUND_W-1:0] roll_r;
  logic signed [ROUND_W-1:0] pitch_r;

  function automatic logic signed [ROUND_W-1:0] round_sat(input angle_t z,
                                                          input logic signed [ROUND_W-1:0] lim);
    angle_t t;
    logic signed [ROUND_W-1:0] r;
    t = z + (ANGLE_W'(1) <<< (ROUND_SHIFT - 1));
    r = t[ANGLE_W-1:ROUND_SHIFT];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  always_comb begin
    if (cfg_q == '0) begin
      block = CFG_W'(1);
    end else if (cfg_q > CFG_W'(MAX_SAMPLES)) begin
      block = CFG_W'(MAX_SAMPLES);
    end else begin
      block = cfg_q;
    end
  end

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  assign count_d        = count_q + 1'b1;
  assign last_sample    = (count_d >= block);

  assign sum_x_d = sum_x_q + {{(SUM_W-SAMPLE_W){sample_i.accel_x[SAMPLE_W-1]}}, sample_i.accel_x};
  assign sum_y_d = sum_y_q + {{(SUM_W-SAMPLE_W){sample_i.accel_y[SAMPLE_W-1]}}, sample_i.accel_y};
  assign sum_z_d = sum_z_q + {{(SUM_W-SAMPLE_W){sample_i.accel_z[SAMPLE_W-1]}}, sample_i.accel_z};

  assign neg_y = -{sum_y_q[SUM_W-1], sum_y_q};
  assign neg_z = -{sum_z_q[SUM_W-1], sum_z_q};
  assign prod  = sum_x_q * GAIN_Q;

  always_comb begin
    creq.start = (state_q == ST_START1) || (state_q == ST_START2);
    if (state_q == ST_START1) begin
      creq.x = {{(WIDE_W-SUM_W-33){neg_z[SUM_W]}}, neg_z, 32'd0};
      creq.y = {{(WIDE_W-SUM_W-33){neg_y[SUM_W]}}, neg_y, 32'd0};
    end else begin
      creq.x = crsp.mag;
      creq.y = prod_q;
    end
  end

  atla_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  assign roll_r   = round_sat(roll_z_q, ROLL_LIM) + ROLL_LIM;
  assign pitch_r  = round_sat(crsp.angle, PITCH_LIM);
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || angle_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_sample) begin
          state_d = ST_START1;
        end
      end
      ST_START1: state_d = ST_PASS1;
      ST_PASS1: begin
        if (crsp.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_START2;
      ST_START2: state_d = ST_PASS2;
      ST_PASS2: begin
        if (crsp.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_W'(CFG_RESET);
      count_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (accept) begin
        sum_x_q <= sum_x_d;
        sum_y_q <= sum_y_d;
        sum_z_q <= sum_z_d;
        count_q <= last_sample ? '0 : count_d;
      end else if (state_q == ST_MUL) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        sum_z_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (angle_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PASS1 && crsp.done) begin
      roll_z_q <= crsp.angle;
    end
    if (state_q == ST_MUL) begin
      prod_q <= WIDE_W'(prod);
    end
    if (load_out) begin
      roll_q  <= ROLL_W'(roll_r);
      pitch_q <= PITCH_W'(pitch_r);
    end
  end

  assign angle_o.valid       = out_valid_q;
  assign angle_o.roll_angle  = roll_q;
  assign angle_o.pitch_angle = pitch_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CFG_W'(MAX_SAMPLES))
    else $error("Sample count reached the block limit without completing a block");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> sum_x_q == '0 && sum_y_q == '0 && sum_z_q == '0 && count_q == '0)
    else $error("Block sums were not cleared after the first pass");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == ST_IDLE)
    else $error("Finished result was not presented");

endmodule

// File: rtl/core/atla_cordic.sv
// Iterative CORDIC vectoring engine, one micro-rotation per clock cycle.
module atla_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atla_pkg::cordic_req_t req_i,
  output atla_pkg::cordic_rsp_t rsp_o
);
  import atla_pkg::*;

  wide_t  x_q, x_d;
  wide_t  y_q, y_d;
  angle_t z_q, z_d;
  step_t  step_q, step_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;
  wide_t  dx;
  wide_t  dy;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    if (req_i.start) begin
      step_d = '0;
      if (req_i.x == '0 && req_i.y == '0) begin
        x_d    = '0;
        y_d    = '0;
        z_d    = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        if (req_i.x < 0) begin
          if (req_i.y >= 0) begin
            x_d = req_i.y;
            y_d = -req_i.x;
            z_d = DEG90_FINE;
          end else begin
            x_d = -req_i.y;
            y_d = req_i.x;
            z_d = -DEG90_FINE;
          end
        end else begin
          x_d = req_i.x;
          y_d = req_i.y;
          z_d = '0;
        end
      end
    end else if (busy_q) begin
      if (!y_q[WIDE_W-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_entry(step_q);
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_entry(step_q);
      end
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.mag   = x_q;
  assign rsp_o.angle = z_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= LAST_STEP)
    else $error("CORDIC step index out of range");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && step_q == LAST_STEP |=> done_q && !busy_q)
    else $error("CORDIC pass did not finish after its last step");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start && req_i.x == '0 && req_i.y == '0 |=> done_q && z_q == '0 && x_q == '0)
    else $error("Zero vector did not give a zero angle at once");

endmodule

// File: test/tb_accelerometer_block_tilt_angles_unit.sv
// Self-checking testbench for the accelerometer block tilt angle unit.
`timescale 1ns / 100ps

module tb_accelerometer_block_tilt_angles_unit;
  import atla_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int REPORT_LIMIT = 10;
  localparam longint INPUT_SCALE = longint'(1) <<< 32;
  localparam longint GAIN_Q = 64'sd7072781453;
  localparam longint QUARTER_TURN = longint'(90) <<< FINE_BITS;
  localparam longint ATAN_FINE [CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7
  };
  localparam logic [CFG_W-1:0] PHASE_BLOCK [RANDOM_PHASES] = '{
    5'd2, 5'd16, 5'd31, 5'd7, 5'd1, 5'd24, 5'd3, 5'd12
  };

  typedef struct {
    roll_t  roll;
    pitch_t pitch;
  } tilt_t;

  class tilt_scoreboard;
    longint sum_x;
    longint sum_y;
    longint sum_z;
    int unsigned sample_count;
    int unsigned block_size;
    tilt_t expected_q[$];
    int mismatches;
    int checked;
    int samples;

    function new();
      block_size = CFG_RESET;
    endfunction

    function void set_block(logic [CFG_W-1:0] value);
      block_size = value;
    endfunction

    function longint vector_angle(longint xa, longint ya, output longint mag);
      longint x;
      longint y;
      longint z;
      longint t;
      longint dx;
      longint dy;
      int i;
      x = xa;
      y = ya;
      z = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        return 0;
      end
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = QUARTER_TURN;
        end else begin
          x = -y;
          y = t;
          z = -QUARTER_TURN;
        end
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_FINE[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_FINE[i];
        end
      end
      mag = x;
      return z;
    endfunction

    function longint round_sat(longint z, longint limit_deg);
      longint r;
      longint lim;
      r = (z + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      lim = limit_deg <<< ANGLE_FRACTION_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function tilt_t predict_tilt();
      longint mag;
      longint roll_fine;
      longint pitch_fine;
      tilt_t t;
      roll_fine = vector_angle((-sum_z) * INPUT_SCALE, (-sum_y) * INPUT_SCALE, mag);
      pitch_fine = vector_angle(mag, sum_x * GAIN_Q, mag);
      t.roll = roll_t'(round_sat(roll_fine, 180) + (longint'(180) <<< ANGLE_FRACTION_BITS));
      t.pitch = pitch_t'(round_sat(pitch_fine, 90));
      return t;
    endfunction

    function void note_sample(sample_t ax, sample_t ay, sample_t az);
      int unsigned eff_block;
      eff_block = block_size;
      if (eff_block == 0) eff_block = 1;
      if (eff_block > MAX_SAMPLES) eff_block = MAX_SAMPLES;
      samples++;
      sum_x += longint'(ax);
      sum_y += longint'(ay);
      sum_z += longint'(az);
      sample_count++;
      if (sample_count < eff_block) return;
      expected_q.push_back(predict_tilt());
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      sample_count = 0;
    endfunction

    function void check_angle(roll_t roll, pitch_t pitch);
      tilt_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected angle result: roll %0d pitch %0d", roll, pitch);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.roll !== roll || want.pitch !== pitch) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Angle mismatch on result %0d: expected roll %0d pitch %0d, got roll %0d pitch %0d",
                   checked, want.roll, want.pitch, roll, pitch);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  int phases_run;
  sample_t base_x;
  sample_t base_y;
  sample_t base_z;
  tilt_scoreboard sb;

  atla_sample_if sample_ch ();
  atla_angle_if angle_ch ();

  accelerometer_block_tilt_angles_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_ch),
    .angle_o     (angle_ch)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    angle_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && angle_ch.valid && angle_ch.ready)
      sb.check_angle(angle_ch.roll_angle, angle_ch.pitch_angle);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((sample_ch.valid && sample_ch.ready) || (angle_ch.valid && angle_ch.ready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(input sample_t ax, input sample_t ay, input sample_t az);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.accel_x <= ax;
    sample_ch.accel_y <= ay;
    sample_ch.accel_z <= az;
    do @(posedge clk_i); while (!sample_ch.ready);
    sb.note_sample(ax, ay, az);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_block_size(input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_block(value);
  endtask

  function automatic sample_t random_component(input sample_t base);
    case ($urandom_range(9))
      0, 1, 2, 3: return sample_t'($urandom);
      4: begin
        case ($urandom_range(4))
          0: return sample_t'(-32768);
          1: return sample_t'(32767);
          2: return sample_t'(0);
          3: return sample_t'(-1);
          default: return sample_t'(1);
        endcase
      end
      5, 6: return sample_t'(int'($urandom_range(16)) - 8);
      default: return base + sample_t'(int'($urandom_range(512)) - 256);
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    angle_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    phases_run = 0;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-sample blocks: axis extremes, zero vector and the half-turn roll.
    write_block_size(5'd1);
    send_sample(0, 0, 0);
    send_sample(0, 0, -32768);
    send_sample(0, 0, 32767);
    send_sample(32767, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(0, 32767, 0);
    send_sample(0, -32768, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    wait_drained();
    write_block_size(5'd0);
    send_sample(12345, -23456, -3000);
    wait_drained();
    write_block_size(5'd31);
    repeat (16) send_sample(-32768, -32768, -32768);
    wait_drained();

    // Shrink the block below the samples already gathered.
    write_block_size(5'd5);
    repeat (4) send_sample(1000, -2000, 16000);
    wait_drained();
    write_block_size(5'd2);
    send_sample(-700, 300, 15000);
    wait_drained();

    base_x = 0;
    base_y = 0;
    base_z = -16384;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_block_size(PHASE_BLOCK[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(19) == 0) begin
          base_x = sample_t'($urandom);
          base_y = sample_t'($urandom);
          base_z = sample_t'($urandom);
        end
        send_sample(random_component(base_x), random_component(base_y),
                    random_component(base_z));
      end
      wait_drained();
      phases_run++;
    end

    $display("Run covered %0d samples over %0d random phases and the directed cases.",
             sb.samples, phases_run);
    $display("Angle results checked: %0d, mismatches: %0d.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: accelerometer_block_tilt_angles_unit.f
rtl/core/atla_pkg.sv
rtl/core/atla_if.sv
rtl/core/atla_cordic.sv
rtl/core/accelerometer_block_tilt_angles_unit.sv
test/tb_accelerometer_block_tilt_angles_unit.sv
